// ===== rtl/pixel_to_bgra8_converter_defines.svh =====
// Assertion macros used by the converter RTL.
`ifndef PIXEL_TO_BGRA8_CONVERTER_DEFINES_SVH
`define PIXEL_TO_BGRA8_CONVERTER_DEFINES_SVH

`ifndef ASSERT_OFF
`define P2B_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
`define P2B_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define P2B_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define P2B_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/p2b_pkg.sv =====
`timescale 1ns / 1ps
package p2b_pkg;

	typedef enum logic [2:0] {
		FMT_BGRA8   = 3'd0,
		FMT_RGBA8   = 3'd1,
		FMT_RGB10A2 = 3'd2,
		FMT_HALF    = 3'd3
	} fmt_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic       supported;
	} result_t;

	localparam logic [4:0]  HALF_EXP_SPECIAL = 5'd31;
	localparam logic [4:0]  HALF_EXP_SAT     = 5'd15;
	localparam logic [31:0] ROUND_HALF       = 32'h0080_0000;
	localparam logic [7:0]  BYTE_MAX         = 8'hFF;
	localparam logic [7:0]  ALPHA_OPAQUE     = 8'hFF;

endpackage

// ===== rtl/p2b_if.sv =====
`timescale 1ns / 1ps
interface p2b_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] pixel_word;
	logic        last_in;

	modport source (output valid, output pixel_word, output last_in, input ready);
	modport sink (input valid, input pixel_word, input last_in, output ready);
endinterface

interface p2b_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] blue;
	logic [7:0] green;
	logic [7:0] red;
	logic [7:0] alpha;
	logic       supported;
	logic       last_out;

	modport source (output valid, output blue, output green, output red, output alpha,
		output supported, output last_out, input ready);
	modport sink (input valid, input blue, input green, input red, input alpha,
		input supported, input last_out, output ready);
endinterface

// ===== rtl/p2b_half_dec.sv =====
`timescale 1ns / 1ps
module p2b_half_dec (
	input  logic [15:0] half_val,
	output logic [7:0]  byte_val
);
	import p2b_pkg::*;

	logic        sgn;
	logic [4:0]  ex;
	logic [9:0]  man;
	logic [3:0]  shamt;
	logic [23:0] count;
	logic [31:0] scaled;
	logic [31:0] rounded;

	assign sgn   = half_val[15];
	assign ex    = half_val[14:10];
	assign man   = half_val[9:0];
	assign shamt = 4'(ex - 5'd1);

	always_comb begin
		if (ex == 5'd0) begin
			count = {14'd0, man};
		end else begin
			count = {13'd0, 1'b1, man} << shamt;
		end
	end

	// The fixed-point value counts units of 2^-24; scale by 255 and round.
	assign scaled  = {count, 8'd0} - {8'd0, count};
	assign rounded = scaled + ROUND_HALF;

	always_comb begin
		if (ex == HALF_EXP_SPECIAL) begin
			byte_val = (man == 10'd0 && !sgn) ? BYTE_MAX : 8'd0;
		end else if (sgn) begin
			byte_val = 8'd0;
		end else if (ex >= HALF_EXP_SAT) begin
			byte_val = BYTE_MAX;
		end else begin
			byte_val = rounded[31:24];
		end
	end
endmodule

// ===== rtl/p2b_decode.sv =====
`timescale 1ns / 1ps
module p2b_decode (
	input  p2b_pkg::fmt_t   fmt,
	input  logic [63:0]     pixel_word,
	output p2b_pkg::result_t res
);
	import p2b_pkg::*;

	logic [7:0] half_r;
	logic [7:0] half_g;
	logic [7:0] half_b;

	p2b_half_dec u_half_r (.half_val(pixel_word[15:0]),  .byte_val(half_r));
	p2b_half_dec u_half_g (.half_val(pixel_word[31:16]), .byte_val(half_g));
	p2b_half_dec u_half_b (.half_val(pixel_word[47:32]), .byte_val(half_b));

	always_comb begin
		res = '0;
		res.supported = 1'b1;
		case (fmt)
			FMT_BGRA8: begin
				res.blue  = pixel_word[7:0];
				res.green = pixel_word[15:8];
				res.red   = pixel_word[23:16];
			end
			FMT_RGBA8: begin
				res.red   = pixel_word[7:0];
				res.green = pixel_word[15:8];
				res.blue  = pixel_word[23:16];
			end
			FMT_RGB10A2: begin
				res.red   = pixel_word[9:2];
				res.green = pixel_word[19:12];
				res.blue  = pixel_word[29:22];
			end
			FMT_HALF: begin
				res.red   = half_r;
				res.green = half_g;
				res.blue  = half_b;
			end
			default: begin
				res.supported = 1'b0;
			end
		endcase
	end
endmodule

// ===== rtl/pixel_to_bgra8_converter.sv =====
`timescale 1ns / 1ps
// An accepted input transaction is registered in the input stage, then decoded and registered in the result stage.
// Throughput is one transaction per cycle while the output is ready, set by the input and result pipeline registers.
// A full stage holds while the stage after it stalls; an empty stage can still take a transaction.
// Reset clears the stage valid flags and sets the source format to BGRA8.
`include "pixel_to_bgra8_converter_defines.svh"
module pixel_to_bgra8_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata,
	p2b_in_if.sink      pix_in,
	p2b_out_if.source   pix_out
);
	import p2b_pkg::*;

	fmt_t        format_q;
	logic        valid_s1;
	logic [63:0] pixel_s1;
	logic        last_s1;
	logic        valid_s2;
	result_t     result_s2;
	logic        last_s2;
	result_t     result_c;
	logic        adv_s2;
	logic        adv_s1;

	assign adv_s2 = !valid_s2 || pix_out.ready;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign pix_in.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q <= FMT_BGRA8;
		end else if (cfg_we) begin
			format_q <= fmt_t'(cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= pix_in.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && pix_in.valid) begin
			pixel_s1 <= pix_in.pixel_word;
			last_s1  <= pix_in.last_in;
		end
		if (adv_s2 && valid_s1) begin
			result_s2 <= result_c;
			last_s2   <= last_s1;
		end
	end

	p2b_decode u_decode (
		.fmt        (format_q),
		.pixel_word (pixel_s1),
		.res        (result_c)
	);

	assign pix_out.valid     = valid_s2;
	assign pix_out.blue      = result_s2.blue;
	assign pix_out.green     = result_s2.green;
	assign pix_out.red       = result_s2.red;
	assign pix_out.alpha     = ALPHA_OPAQUE;
	assign pix_out.supported = result_s2.supported;
	assign pix_out.last_out  = last_s2;

	`P2B_ASSERT_NEXT(a_s1_to_s2, clk, arst_n, valid_s1 && adv_s2, valid_s2)
	`P2B_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !adv_s2, valid_s1 && $stable(pixel_s1))
	`P2B_ASSERT_IMPL(a_unsup_zero, clk, arst_n, valid_s2 && !result_s2.supported,
		result_s2.blue == 8'd0 && result_s2.green == 8'd0 && result_s2.red == 8'd0)
endmodule

// ===== tb/tb_pixel_to_bgra8_converter.sv =====
`timescale 1ns / 1ps
module tb_pixel_to_bgra8_converter;
	import p2b_pkg::*;

	localparam logic [2:0] FMT_UNSUPPORTED = 3'd4;
	localparam int RANDOM_PHASES = 10;
	localparam int PIXELS_PER_PHASE = 125;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] alpha;
		logic       supported;
		logic       last_out;
	} bgra_t;

	typedef struct packed {
		logic [2:0]  fmt;
		logic [63:0] word;
		logic        row_end;
		logic        typed;
		bgra_t       want;
	} pixel_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_wdata;

	p2b_in_if  pix_in ();
	p2b_out_if pix_out ();

	pixel_to_bgra8_converter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pix_in    (pix_in),
		.pix_out   (pix_out)
	);

	bgra_t expected_pixels[$];
	logic [2:0] fmt_now;
	bit calm;
	int fault_count;

	pixel_row_t directed_rows [0:22] = '{
		'{FMT_BGRA8, 64'h0, 1'b0, 1'b1, '{8'h00, 8'h00, 8'h00, ALPHA_OPAQUE, 1'b1, 1'b0}},
		'{FMT_BGRA8, '1, 1'b1, 1'b1, '{8'hFF, 8'hFF, 8'hFF, ALPHA_OPAQUE, 1'b1, 1'b1}},
		'{FMT_BGRA8, 64'h0000_0000_0033_2211, 1'b0, 1'b1,
			'{8'h11, 8'h22, 8'h33, ALPHA_OPAQUE, 1'b1, 1'b0}},
		'{FMT_BGRA8, 64'hFFFF_FFFF_FF00_0000, 1'b1, 1'b1,
			'{8'h00, 8'h00, 8'h00, ALPHA_OPAQUE, 1'b1, 1'b1}},
		'{FMT_RGBA8, 64'h0000_0000_0033_2211, 1'b0, 1'b1,
			'{8'h33, 8'h22, 8'h11, ALPHA_OPAQUE, 1'b1, 1'b0}},
		'{FMT_RGBA8, '1, 1'b1, 1'b1, '{8'hFF, 8'hFF, 8'hFF, ALPHA_OPAQUE, 1'b1, 1'b1}},
		'{FMT_RGB10A2, '1, 1'b0, 1'b1, '{8'hFF, 8'hFF, 8'hFF, ALPHA_OPAQUE, 1'b1, 1'b0}},
		'{FMT_RGB10A2, 64'h0, 1'b1, 1'b1, '{8'h00, 8'h00, 8'h00, ALPHA_OPAQUE, 1'b1, 1'b1}},
		'{FMT_RGB10A2, 64'hC000_0000_2000_03FF, 1'b0, 1'b0, '0},
		'{FMT_RGB10A2, 64'hFFFF_FFFF_C000_0000, 1'b0, 1'b1,
			'{8'h00, 8'h00, 8'h00, ALPHA_OPAQUE, 1'b1, 1'b0}},
		'{FMT_HALF, 64'h0, 1'b0, 1'b1, '{8'h00, 8'h00, 8'h00, ALPHA_OPAQUE, 1'b1, 1'b0}},
		'{FMT_HALF, 64'h0000_3C00_3C00_3C00, 1'b1, 1'b1,
			'{8'hFF, 8'hFF, 8'hFF, ALPHA_OPAQUE, 1'b1, 1'b1}},
		'{FMT_HALF, 64'h0000_8000_8000_8000, 1'b0, 1'b1,
			'{8'h00, 8'h00, 8'h00, ALPHA_OPAQUE, 1'b1, 1'b0}},
		'{FMT_HALF, 64'h0000_FC00_7C00_7C00, 1'b0, 1'b1,
			'{8'h00, 8'hFF, 8'hFF, ALPHA_OPAQUE, 1'b1, 1'b0}},
		'{FMT_HALF, 64'h0000_7C01_FE01_7E00, 1'b1, 1'b1,
			'{8'h00, 8'h00, 8'h00, ALPHA_OPAQUE, 1'b1, 1'b1}},
		'{FMT_HALF, 64'h0000_7BFF_4000_3C01, 1'b0, 1'b1,
			'{8'hFF, 8'hFF, 8'hFF, ALPHA_OPAQUE, 1'b1, 1'b0}},
		'{FMT_HALF, 64'h0000_BC00_8001_FBFF, 1'b0, 1'b1,
			'{8'h00, 8'h00, 8'h00, ALPHA_OPAQUE, 1'b1, 1'b0}},
		'{FMT_HALF, 64'hFFFF_0000_0000_0000, 1'b1, 1'b1,
			'{8'h00, 8'h00, 8'h00, ALPHA_OPAQUE, 1'b1, 1'b1}},
		'{FMT_HALF, 64'h0000_03FF_0400_0001, 1'b0, 1'b0, '0},
		'{FMT_HALF, 64'h0000_3800_1C04_3BFF, 1'b0, 1'b0, '0},
		'{FMT_UNSUPPORTED, '1, 1'b1, 1'b1, '{8'h00, 8'h00, 8'h00, ALPHA_OPAQUE, 1'b0, 1'b1}},
		'{FMT_UNSUPPORTED, 64'h0, 1'b0, 1'b1, '{8'h00, 8'h00, 8'h00, ALPHA_OPAQUE, 1'b0, 1'b0}},
		'{FMT_BGRA8, 64'h0000_0000_00A5_5AC3, 1'b0, 1'b1,
			'{8'hC3, 8'h5A, 8'hA5, ALPHA_OPAQUE, 1'b1, 1'b0}}
	};

	function automatic logic [7:0] half_channel_byte(input logic [15:0] h);
		logic [4:0]  expo;
		logic [9:0]  mant;
		logic [39:0] count;
		expo = h[14:10];
		mant = h[9:0];
		if (expo == HALF_EXP_SPECIAL) begin
			return (mant == 10'd0 && !h[15]) ? BYTE_MAX : 8'd0;
		end
		if (h[15]) begin
			return 8'd0;
		end
		if (expo >= HALF_EXP_SAT) begin
			return BYTE_MAX;
		end
		if (expo == 5'd0) begin
			count = {30'd0, mant};
		end else begin
			count = (40'd1024 + {30'd0, mant}) << (expo - 5'd1);
		end
		count = (count * 40'd255 + 40'h80_0000) >> 24;
		return count[7:0];
	endfunction

	function automatic bgra_t convert_pixel(input logic [2:0] fmt, input logic [63:0] w,
			input logic row_end);
		bgra_t p;
		p = '{8'd0, 8'd0, 8'd0, ALPHA_OPAQUE, 1'b1, row_end};
		case (fmt)
			FMT_BGRA8: begin
				p.blue  = w[7:0];
				p.green = w[15:8];
				p.red   = w[23:16];
			end
			FMT_RGBA8: begin
				p.red   = w[7:0];
				p.green = w[15:8];
				p.blue  = w[23:16];
			end
			FMT_RGB10A2: begin
				p.red   = w[9:2];
				p.green = w[19:12];
				p.blue  = w[29:22];
			end
			FMT_HALF: begin
				p.red   = half_channel_byte(w[15:0]);
				p.green = half_channel_byte(w[31:16]);
				p.blue  = half_channel_byte(w[47:32]);
			end
			default: begin
				p.supported = 1'b0;
			end
		endcase
		return p;
	endfunction

	function automatic int idle_length();
		int r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [15:0] random_half();
		case ($urandom_range(0, 5))
			0: return 16'($urandom);
			1: return {1'b0, 5'($urandom_range(0, 14)), 10'($urandom)};
			2: return {1'b0, 5'd0, 10'($urandom)};
			3: return {1'b0, 5'd14, 10'($urandom)};
			4: return {1'($urandom), HALF_EXP_SPECIAL, ($urandom_range(0, 1) == 0) ? 10'd0
				: 10'($urandom)};
			default: return {1'b0, 5'($urandom_range(15, 30)), 10'($urandom)};
		endcase
	endfunction

	function automatic logic [63:0] random_word(input logic [2:0] fmt);
		if (fmt == FMT_HALF && $urandom_range(0, 4) != 0) begin
			return {16'($urandom), random_half(), random_half(), random_half()};
		end
		return {$urandom, $urandom};
	endfunction

	task automatic push_pixel(input logic [63:0] w, input logic row_end, input bgra_t want);
		int gap;
		gap = idle_length();
		@(negedge clk);
		if (gap > 0) begin
			pix_in.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_in.valid = 1'b1;
		pix_in.pixel_word = w;
		pix_in.last_in = row_end;
		do @(posedge clk); while (!pix_in.ready);
		expected_pixels.push_back(want);
	endtask

	task automatic drain_pixels();
		@(negedge clk);
		pix_in.valid = 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_format(input logic [2:0] fmt);
		drain_pixels();
		cfg_we = 1'b1;
		cfg_wdata = fmt;
		@(negedge clk);
		cfg_we = 1'b0;
		fmt_now = fmt;
	endtask

	initial begin
		clk = 1'b0;
	end

	always #4 clk = ~clk;

	initial begin
		#5_000_000;
		$display("[pixel_to_bgra8_converter] ERROR");
		$finish;
	end

	initial begin
		logic [63:0] w;
		logic row_end;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 3'd0;
		pix_in.valid = 1'b0;
		pix_in.pixel_word = 64'd0;
		pix_in.last_in = 1'b0;
		fmt_now = FMT_BGRA8;
		calm = 1'b0;
		fault_count = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].fmt != fmt_now) begin
				set_format(directed_rows[i].fmt);
			end
			push_pixel(directed_rows[i].word, directed_rows[i].row_end,
				directed_rows[i].typed ? directed_rows[i].want
				: convert_pixel(fmt_now, directed_rows[i].word, directed_rows[i].row_end));
		end

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			calm = (phase == 3 || phase == 7);
			set_format((phase < 5) ? 3'(phase) : 3'($urandom_range(0, 4)));
			repeat (PIXELS_PER_PHASE) begin
				w = random_word(fmt_now);
				row_end = ($urandom_range(0, 7) == 0);
				push_pixel(w, row_end, convert_pixel(fmt_now, w, row_end));
			end
		end

		drain_pixels();
		if (fault_count == 0) begin
			$display("[pixel_to_bgra8_converter] OK");
		end else begin
			$display("[pixel_to_bgra8_converter] ERROR");
		end
		$finish;
	end

	initial begin
		int run_left;
		pix_out.ready = 1'b0;
		run_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (run_left > 0) begin
				run_left--;
			end else if (pix_out.ready) begin
				run_left = idle_length();
				if (run_left > 0) begin
					pix_out.ready = 1'b0;
					run_left--;
				end else begin
					run_left = $urandom_range(0, 12);
				end
			end else begin
				pix_out.ready = 1'b1;
				run_left = $urandom_range(0, 12);
			end
		end
	end

	always @(posedge clk) begin : check_results
		bgra_t seen;
		bgra_t want;
		if (arst_n && pix_out.valid && pix_out.ready) begin
			seen = '{pix_out.blue, pix_out.green, pix_out.red, pix_out.alpha,
				pix_out.supported, pix_out.last_out};
			if (expected_pixels.size() == 0) begin
				fault_count++;
				if (fault_count <= 10) begin
					$display("unexpected transaction: b=%h g=%h r=%h a=%h sup=%b last=%b",
						seen.blue, seen.green, seen.red, seen.alpha, seen.supported,
						seen.last_out);
				end
			end else begin
				want = expected_pixels.pop_front();
				if (seen !== want) begin
					fault_count++;
					if (fault_count <= 10) begin
						$display("mismatch: expected b=%h g=%h r=%h a=%h sup=%b last=%b",
							want.blue, want.green, want.red, want.alpha, want.supported,
							want.last_out);
						$display("          actual   b=%h g=%h r=%h a=%h sup=%b last=%b",
							seen.blue, seen.green, seen.red, seen.alpha, seen.supported,
							seen.last_out);
					end
				end
			end
		end
	end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/p2b_pkg.sv
rtl/p2b_if.sv
rtl/p2b_half_dec.sv
rtl/p2b_decode.sv
rtl/pixel_to_bgra8_converter.sv
tb/tb_pixel_to_bgra8_converter.sv
